[sv/adc_event_bank_deframer_macros.svh]
// Assertion macros for the ADC event bank deframer.
// The module that uses them must have a clock i_clk and an active-low reset i_rst_n.
`ifndef ADC_EVENT_BANK_DEFRAMER_MACROS_SVH
`define ADC_EVENT_BANK_DEFRAMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AEBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AEBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/aebd_pkg.sv]
// Shared types and constants of the ADC event bank deframer.
// No dependencies; used by the interfaces, the window RAM and the top level.
`timescale 1ns / 1ps

package aebd_pkg;

    localparam int CHANNELS_DEF = 12;

    typedef logic [15:0]        t_word;
    typedef logic [11:0]        t_trig;
    typedef logic [3:0]         t_chan;
    typedef logic signed [16:0] t_adc;

    localparam t_word END_MARK  = 16'hFFFF;
    localparam t_word CHECK_RST = 16'hFEED;
    localparam t_word COUNT_MAX = 16'hFFFF;
    localparam t_adc  ADC_SHORT = 17'h1FFFF;

endpackage

[sv/aebd_ifs.sv]
// Valid/ready channel interfaces of the ADC event bank deframer.
// Depends on aebd_pkg for the payload types.
`timescale 1ns / 1ps

interface aebd_in_if;
    logic           valid;
    logic           ready;
    aebd_pkg::t_word data_word;
    logic           bank_start;

    modport source (output valid, output data_word, output bank_start, input ready);
    modport sink   (input valid, input data_word, input bank_start, output ready);
endinterface

interface aebd_cfg_if;
    logic            valid;
    logic            ready;
    aebd_pkg::t_word check_word;

    modport source (output valid, output check_word, input ready);
    modport sink   (input valid, input check_word, output ready);
endinterface

interface aebd_out_if;
    logic            valid;
    logic            ready;
    logic            kind;
    aebd_pkg::t_word event_index;
    aebd_pkg::t_chan channel;
    aebd_pkg::t_adc  adc_value;
    logic            checkword_ok;
    logic            short_event;
    logic            last_of_event;
    aebd_pkg::t_word event_count;
    aebd_pkg::t_trig triggers_expected;
    logic            trigger_match;
    logic            any_check_fail;

    modport source (
        output valid, output kind, output event_index, output channel, output adc_value,
        output checkword_ok, output short_event, output last_of_event, output event_count,
        output triggers_expected, output trigger_match, output any_check_fail,
        input ready
    );
    modport sink (
        input valid, input kind, input event_index, input channel, input adc_value,
        input checkword_ok, input short_event, input last_of_event, input event_count,
        input triggers_expected, input trigger_match, input any_check_fail,
        output ready
    );
endinterface

[sv/adc_event_bank_deframer.sv]
// ADC event bank deframer, top level. Uses aebd_pkg, aebd_ifs and aebd_win_ram.
// Words are taken one per cycle while a window fills and the read stage is empty; the word
// that completes a window starts the channel readout, one result per channel, read from
// the window RAM unless the event is short; input resumes after the readout, once the read
// stage is empty. A result is registered in the read stage and then in the output register.
// Reset (synchronous, active low) clears all control state and loads check_word with 0xFEED.
`timescale 1ns / 1ps
`include "adc_event_bank_deframer_macros.svh"

module adc_event_bank_deframer #(
    parameter int CHANNELS = aebd_pkg::CHANNELS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    aebd_in_if.sink    i_in,
    aebd_cfg_if.sink   i_cfg,
    aebd_out_if.source o_out
);

    // A window holds one leading word, CHANNELS samples and the checkword.
    localparam int WINDOW = CHANNELS + 2;
    localparam int AW     = $clog2(WINDOW);
    localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [AW-1:0] FILL_LAST = AW'(WINDOW - 1);
    localparam logic [CW-1:0] CH_LAST   = CW'(CHANNELS - 1);

    // Sequencer states: collecting words, reading out channels, issuing the bank summary.
    localparam logic [1:0] S_COLLECT = 2'd0;
    localparam logic [1:0] S_EMIT    = 2'd1;
    localparam logic [1:0] S_SUM     = 2'd2;

    // Configuration.
    aebd_pkg::t_word r_check_word;

    // Bank and window state.
    logic [1:0]      r_state, n_state;
    logic            r_in_bank, n_in_bank;
    logic [AW-1:0]   r_fill, n_fill;
    aebd_pkg::t_trig r_expected, n_expected;
    aebd_pkg::t_word r_events, n_events;
    logic            r_fail, n_fail;
    aebd_pkg::t_word r_prev, n_prev;

    // Per-event results, fixed while its channels are read out.
    aebd_pkg::t_word r_evt_idx, n_evt_idx;
    logic            r_evt_ok, n_evt_ok;
    logic            r_evt_short, n_evt_short;
    logic            r_carry_end, n_carry_end;
    logic [CW-1:0]   r_ch, n_ch;

    // Read stage: the RAM read register plus the tags of the result it belongs to.
    logic            r_s1_valid, n_s1_valid;
    logic            r_s1_kind, n_s1_kind;
    logic [CW-1:0]   r_s1_chan, n_s1_chan;
    logic            r_s1_last, n_s1_last;

    // Output register.
    logic            r_out_valid;
    logic            r_out_kind;
    aebd_pkg::t_word r_out_idx;
    aebd_pkg::t_chan r_out_chan;
    aebd_pkg::t_adc  r_out_adc;
    logic            r_out_ok;
    logic            r_out_short;
    logic            r_out_last;
    aebd_pkg::t_word r_out_count;
    aebd_pkg::t_trig r_out_trig;
    logic            r_out_match;
    logic            r_out_anyf;

    logic            w_in_acc;
    logic            w_out_free;
    logic            w_issue;
    logic            w_move;
    logic            w_wr_en;
    logic            w_rd_en;
    logic            w_win_done;
    logic            w_word_ok;
    logic            w_short;
    logic            w_ch_last;
    logic [AW-1:0]   w_rd_addr;
    aebd_pkg::t_word w_rd_data;

    // Config register always writable; the user must write only while idle (unchecked).
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_word <= aebd_pkg::CHECK_RST;
        end else if (i_cfg.valid) begin
            r_check_word <= i_cfg.check_word;
        end
    end

    // Input is taken only while collecting and with the read stage empty, so the
    // counters that a summary reads are stable until that summary has left the stage.
    // This also keeps window writes and channel reads in separate cycles.
    assign i_in.ready = (r_state == S_COLLECT) && !r_s1_valid;
    assign w_in_acc   = i_in.valid && i_in.ready;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_move     = r_s1_valid && w_out_free;
    assign w_issue    = !r_s1_valid || w_out_free;

    // Checks on the word that completes a window, against the word before it.
    assign w_word_ok = (i_in.data_word == r_check_word);
    assign w_short   = !w_word_ok && (r_prev == r_check_word);
    assign w_ch_last = (r_ch == CH_LAST);

    // Channel c sits at window entry c+1; entry 0 is skipped.
    assign w_rd_addr = AW'(r_ch) + AW'(1);

    always_comb begin
        n_state     = r_state;
        n_in_bank   = r_in_bank;
        n_fill      = r_fill;
        n_expected  = r_expected;
        n_events    = r_events;
        n_fail      = r_fail;
        n_prev      = r_prev;
        n_evt_idx   = r_evt_idx;
        n_evt_ok    = r_evt_ok;
        n_evt_short = r_evt_short;
        n_carry_end = r_carry_end;
        n_ch        = r_ch;
        n_s1_valid  = r_s1_valid && !w_move;
        n_s1_kind   = r_s1_kind;
        n_s1_chan   = r_s1_chan;
        n_s1_last   = r_s1_last;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;
        w_win_done  = 1'b0;

        unique case (r_state)
            S_COLLECT: begin
                if (w_in_acc) begin
                    if (i_in.bank_start) begin
                        // A header opens a new bank and drops any open one.
                        n_expected = i_in.data_word[11:0];
                        n_in_bank  = 1'b1;
                        n_fill     = '0;
                        n_events   = '0;
                        n_fail     = 1'b0;
                    end else if (r_in_bank) begin
                        if ((r_fill == '0) && (i_in.data_word == aebd_pkg::END_MARK)) begin
                            n_state   = S_SUM;
                            n_in_bank = 1'b0;
                        end else begin
                            w_wr_en = 1'b1;
                            n_prev  = i_in.data_word;
                            if (r_fill == FILL_LAST) begin
                                w_win_done  = 1'b1;
                                n_evt_idx   = r_events;
                                if (r_events != aebd_pkg::COUNT_MAX) begin
                                    n_events = r_events + 16'd1;
                                end
                                n_evt_short = w_short;
                                n_evt_ok    = w_word_ok || w_short;
                                if (!(w_word_ok || w_short)) begin
                                    n_fail = 1'b1;
                                end
                                // A short event leaves its last word as the first word
                                // of the next window; an end marker there closes the bank.
                                n_carry_end = w_short && (i_in.data_word == aebd_pkg::END_MARK);
                                n_fill      = w_short ? AW'(1) : '0;
                                if (w_short && (i_in.data_word == aebd_pkg::END_MARK)) begin
                                    n_in_bank = 1'b0;
                                    n_fill    = '0;
                                end
                                n_ch    = '0;
                                n_state = S_EMIT;
                            end else begin
                                n_fill = r_fill + AW'(1);
                            end
                        end
                    end
                end
            end
            S_EMIT: begin
                if (w_issue) begin
                    w_rd_en    = !r_evt_short;
                    n_s1_valid = 1'b1;
                    n_s1_kind  = 1'b0;
                    n_s1_chan  = r_ch;
                    n_s1_last  = w_ch_last && !r_carry_end;
                    if (w_ch_last) begin
                        n_ch    = '0;
                        n_state = r_carry_end ? S_SUM : S_COLLECT;
                    end else begin
                        n_ch = r_ch + CW'(1);
                    end
                end
            end
            S_SUM: begin
                if (w_issue) begin
                    n_s1_valid = 1'b1;
                    n_s1_kind  = 1'b1;
                    n_s1_chan  = '0;
                    n_s1_last  = 1'b1;
                    n_state    = S_COLLECT;
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_COLLECT;
            r_in_bank  <= 1'b0;
            r_fill     <= '0;
            r_expected <= '0;
            r_events   <= '0;
            r_fail     <= 1'b0;
            r_ch       <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_bank  <= n_in_bank;
            r_fill     <= n_fill;
            r_expected <= n_expected;
            r_events   <= n_events;
            r_fail     <= n_fail;
            r_ch       <= n_ch;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev      <= n_prev;
        r_evt_idx   <= n_evt_idx;
        r_evt_ok    <= n_evt_ok;
        r_evt_short <= n_evt_short;
        r_carry_end <= n_carry_end;
        r_s1_kind   <= n_s1_kind;
        r_s1_chan   <= n_s1_chan;
        r_s1_last   <= n_s1_last;
    end

    aebd_win_ram #(
        .DEPTH (WINDOW)
    ) u_win_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_fill),
        .i_wr_data (i_in.data_word),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Output register: loaded from the read stage, cleared when its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_kind <= r_s1_kind;
            r_out_last <= r_s1_last;
            if (r_s1_kind) begin
                r_out_idx   <= '0;
                r_out_chan  <= '0;
                r_out_adc   <= '0;
                r_out_ok    <= 1'b0;
                r_out_short <= 1'b0;
                r_out_count <= r_events;
                r_out_trig  <= r_expected;
                r_out_match <= (r_events == {4'b0, r_expected});
                r_out_anyf  <= r_fail;
            end else begin
                r_out_idx   <= r_evt_idx;
                r_out_chan  <= 4'(r_s1_chan);
                r_out_adc   <= r_evt_short ? aebd_pkg::ADC_SHORT : {1'b0, w_rd_data};
                r_out_ok    <= r_evt_ok;
                r_out_short <= r_evt_short;
                r_out_count <= '0;
                r_out_trig  <= '0;
                r_out_match <= 1'b0;
                r_out_anyf  <= 1'b0;
            end
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.kind              = r_out_kind;
    assign o_out.event_index       = r_out_idx;
    assign o_out.channel           = r_out_chan;
    assign o_out.adc_value         = r_out_adc;
    assign o_out.checkword_ok      = r_out_ok;
    assign o_out.short_event       = r_out_short;
    assign o_out.last_of_event     = r_out_last;
    assign o_out.event_count       = r_out_count;
    assign o_out.triggers_expected = r_out_trig;
    assign o_out.trigger_match     = r_out_match;
    assign o_out.any_check_fail    = r_out_anyf;

    // The window RAM is never read and written in the same cycle.
    `AEBD_ASSERT_NOW(a_ram_no_overlap, w_rd_en, !w_wr_en, "window RAM read and write overlap")
    // A completed window always starts the channel readout.
    `AEBD_ASSERT_NEXT(a_done_emits, w_win_done, r_state == S_EMIT, "window done without readout")
    // A summary is always the last result of its input.
    `AEBD_ASSERT_NOW(a_sum_last, r_out_valid && r_out_kind, r_out_last, "summary not marked last")
    // The fill count stays inside the window.
    `AEBD_ASSERT_NOW(a_fill_range, 1'b1, r_fill <= FILL_LAST, "window fill out of range")

endmodule

[sv/aebd_win_ram.sv]
// Event window store: one write port, one read port with a registered read.
// Depends on aebd_pkg for the word type and the default depth.
`timescale 1ns / 1ps

module aebd_win_ram #(
    parameter int  DEPTH = aebd_pkg::CHANNELS_DEF + 2,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  aebd_pkg::t_word i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output aebd_pkg::t_word o_rd_data
);

    aebd_pkg::t_word r_mem [DEPTH];
    aebd_pkg::t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // The read register holds its value while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[test/testbench.sv]
// Self-checking testbench for the ADC event bank deframer.
// Needs aebd_pkg, the aebd_ifs interfaces and the adc_event_bank_deframer RTL.
// Whole banks of words are sent, and every result is checked against a built-in predictor.
`timescale 1ns / 1ps

module testbench;

    typedef aebd_pkg::t_word t_word;
    typedef aebd_pkg::t_trig t_trig;
    typedef aebd_pkg::t_chan t_chan;
    typedef aebd_pkg::t_adc  t_adc;

    localparam t_word END_MARK  = aebd_pkg::END_MARK;
    localparam t_word CHECK_RST = aebd_pkg::CHECK_RST;
    localparam t_word COUNT_MAX = aebd_pkg::COUNT_MAX;
    localparam t_adc  ADC_SHORT = aebd_pkg::ADC_SHORT;

    localparam int CHANNELS    = aebd_pkg::CHANNELS_DEF;
    localparam int WINDOW      = CHANNELS + 2;
    // Longest internal activity after the last result, with margin.
    localparam int SETTLE      = 2 * CHANNELS + 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic  kind;
        t_word event_index;
        t_chan channel;
        t_adc  adc_value;
        logic  checkword_ok;
        logic  short_event;
        logic  last_of_event;
        t_word event_count;
        t_trig triggers_expected;
        logic  trigger_match;
        logic  any_check_fail;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    aebd_in_if  in_if ();
    aebd_cfg_if cfg_if ();
    aebd_out_if out_if ();

    adc_event_bank_deframer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // Predictor state, kept in step with every accepted transfer.
    t_word        cur_check = CHECK_RST;
    t_word        win_words [WINDOW];
    int           win_count = 0;
    bit           bank_open = 1'b0;
    t_trig        hdr_triggers = '0;
    t_word        event_total = '0;
    bit           bad_check_seen = 1'b0;
    t_result      results_due [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int error_count   = 0;
    int cycle_count   = 0;
    int bank_words    = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic void close_bank();
        t_result r;
        r = '0;
        r.kind              = 1'b1;
        r.last_of_event     = 1'b1;
        r.event_count       = event_total;
        r.triggers_expected = hdr_triggers;
        r.trigger_match     = (event_total == {4'b0, hdr_triggers});
        r.any_check_fail    = bad_check_seen;
        results_due.insert(results_due.size(), r);
        bank_open = 1'b0;
        win_count = 0;
    endfunction

    function automatic void deframe_word(input t_word w, input logic start);
        t_result r;
        t_word   idx;
        bit      ok;
        if (start) begin
            hdr_triggers   = w[11:0];
            bank_open      = 1'b1;
            win_count      = 0;
            event_total    = '0;
            bad_check_seen = 1'b0;
            return;
        end
        if (!bank_open) return;
        if (win_count == 0 && w == END_MARK) begin
            close_bank();
            return;
        end
        win_words[win_count] = w;
        win_count++;
        if (win_count < WINDOW) return;

        idx = event_total;
        if (event_total != COUNT_MAX) event_total++;

        // Short event: the checkword sits one word early, and the last word opens
        // the next window.
        if (win_words[WINDOW-1] != cur_check && win_words[WINDOW-2] == cur_check) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r = '0;
                r.event_index   = idx;
                r.channel       = t_chan'(i);
                r.adc_value     = ADC_SHORT;
                r.checkword_ok  = 1'b1;
                r.short_event   = 1'b1;
                r.last_of_event = (i == CHANNELS - 1) && (win_words[WINDOW-1] != END_MARK);
                results_due.insert(results_due.size(), r);
            end
            win_words[0] = win_words[WINDOW-1];
            win_count    = 1;
            if (win_words[0] == END_MARK) close_bank();
            return;
        end

        ok = (win_words[WINDOW-1] == cur_check);
        if (!ok) bad_check_seen = 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
            r = '0;
            r.event_index   = idx;
            r.channel       = t_chan'(i);
            r.adc_value     = t_adc'({1'b0, win_words[i+1]});
            r.checkword_ok  = ok;
            r.last_of_event = (i == CHANNELS - 1);
            results_due.insert(results_due.size(), r);
        end
        win_count = 0;
    endfunction

    // ---------------------------------------------------------------- result checking

    function automatic string show(input t_result r);
        return {$sformatf("kind=%0d ev=%0d ch=%0d adc=%0d ok=%0d short=%0d ",
                          r.kind, r.event_index, r.channel, r.adc_value, r.checkword_ok,
                          r.short_event),
                $sformatf("last=%0d cnt=%0d trig=%0d match=%0d fail=%0d",
                          r.last_of_event, r.event_count, r.triggers_expected,
                          r.trigger_match, r.any_check_fail)};
    endfunction

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.kind              = out_if.kind;
            got.event_index       = out_if.event_index;
            got.channel           = out_if.channel;
            got.adc_value         = out_if.adc_value;
            got.checkword_ok      = out_if.checkword_ok;
            got.short_event       = out_if.short_event;
            got.last_of_event     = out_if.last_of_event;
            got.event_count       = out_if.event_count;
            got.triggers_expected = out_if.triggers_expected;
            got.trigger_match     = out_if.trigger_match;
            got.any_check_fail    = out_if.any_check_fail;
            if (results_due.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %s", $time, show(got));
            end else begin
                want = results_due.pop_front();
                if (got !== want) begin
                    error_count++;
                    $display("%0t: result mismatch, expected %s, actual %s",
                             $time, show(want), show(got));
                end
            end
        end
    end

    // The receiver stalls at random, or for a long stretch while hold_left runs down.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_word(input t_word w, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.data_word  <= w;
        in_if.bank_start <= start;
        do @(posedge i_clk); while (!in_if.ready);
        deframe_word(w, start);
    endtask

    task automatic write_check_word(input t_word v);
        cfg_if.valid      <= 1'b1;
        cfg_if.check_word <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cur_check = v;
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- stimulus helpers

    // A word that may open an event window: not the end marker, not the checkword.
    function automatic t_word opening_word();
        t_word w;
        do w = t_word'($urandom); while (w == END_MARK || w == cur_check);
        return w;
    endfunction

    function automatic t_word pick_sample();
        case ($urandom_range(15))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h0001;
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic t_word non_check_word();
        t_word w;
        do w = pick_sample(); while (w == cur_check);
        return w;
    endfunction

    // One bank of well-formed events with random content: mostly normal events, some
    // short or with a bad checkword, usually closed by the end marker, sometimes left
    // open with a partial window so that the next header abandons it.
    task automatic send_bank(input int n_events);
        t_word w;
        int    sort;
        int    ending;
        w       = t_word'($urandom);
        w[11:0] = ($urandom_range(1) != 0) ? t_trig'(n_events) : t_trig'($urandom);
        send_word(w, 1'b1);
        bank_words++;
        for (int e = 0; e < n_events; e++) begin
            sort = $urandom_range(9);
            send_word(opening_word(), 1'b0);
            for (int s = 1; s < CHANNELS; s++) send_word(pick_sample(), 1'b0);
            if (sort >= 6 && sort <= 7) begin
                // Short event: the word after the checkword opens the next event.
                send_word(cur_check, 1'b0);
                bank_words += CHANNELS + 1;
            end else begin
                send_word(sort >= 8 ? non_check_word() : pick_sample(), 1'b0);
                send_word(sort >= 8 ? non_check_word() : cur_check, 1'b0);
                bank_words += CHANNELS + 2;
            end
        end
        ending = $urandom_range(9);
        if (ending < 8) begin
            send_word(END_MARK, 1'b0);
            bank_words++;
            // Stray words between banks are ignored by the block.
            repeat ($urandom_range(2)) send_word(t_word'($urandom), 1'b0);
        end else begin
            repeat ($urandom_range(1, 5)) begin
                send_word(non_check_word(), 1'b0);
                bank_words++;
            end
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_outside_bank();
        send_word(END_MARK, 1'b0);
        send_word(CHECK_RST, 1'b0);
    endtask

    task automatic test_empty_bank();
        send_word(16'hFFFF, 1'b1);   // trigger count 0xfff, never matched
        send_word(END_MARK, 1'b0);
        send_word(16'h0000, 1'b1);   // trigger count 0 matches an empty bank
        send_word(END_MARK, 1'b0);
    endtask

    task automatic test_header_abort();
        send_word(16'h0003, 1'b1);
        send_word(16'h1111, 1'b0);
        send_word(16'h2222, 1'b0);
    endtask

    // A short event whose carried word is the end marker: the channel results are
    // followed by the summary from the same transfer.
    task automatic test_short_then_end();
        send_word(16'hF001, 1'b1);
        send_word(16'h0000, 1'b0);
        for (int s = 1; s < CHANNELS; s++)
            send_word((s % 2) ? 16'hFFFF : t_word'(s), 1'b0);
        send_word(cur_check, 1'b0);
        send_word(END_MARK, 1'b0);
    endtask

    task automatic test_random_banks(input int target);
        bank_words = 0;
        while (bank_words < target) send_bank($urandom_range(0, 3));
    endtask

    // The receiver holds off long enough for the block to stall its input; later the
    // sender stops until every result is out.
    task automatic test_pressure();
        send_idle_pct = 0;
        recv_idle_pct = 20;
        hold_left     = 300;
        send_bank(3);
        wait_drained();
        send_bank(2);
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.data_word   <= '0;
        in_if.bank_start  <= 1'b0;
        cfg_if.valid      <= 1'b0;
        cfg_if.check_word <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 38;
        recv_idle_pct = 62;
        test_outside_bank();
        test_empty_bank();
        test_header_abort();
        test_short_then_end();
        wait_drained();

        write_check_word(16'h0000);
        test_random_banks(75);
        wait_drained();

        send_idle_pct = 62;
        recv_idle_pct = 38;
        write_check_word(16'hFFFF);
        test_random_banks(75);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_check_word(t_word'($urandom));
        test_random_banks(70);
        wait_drained();

        write_check_word(t_word'($urandom));
        test_pressure();
        wait_drained();

        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

[adc_event_bank_deframer.f]
+incdir+sv
sv/aebd_pkg.sv
sv/aebd_ifs.sv
sv/aebd_win_ram.sv
sv/adc_event_bank_deframer.sv
test/testbench.sv
